// ----- rtl/core/zlrc_pkg.sv -----
// Shared types and constants for the zoned lock reference counter.
`timescale 1ns / 1ps
`default_nettype none
package zlrc_pkg;

  localparam int NUM_LOCKS = 256;
  localparam int LOCK_W    = 8;
  localparam int ZONE_W    = 2;
  localparam int ZADDR_W   = ZONE_W + LOCK_W;
  localparam int CNT_W     = 16;
  localparam int HOLD_W    = 3;
  localparam int CMD_W     = 4;
  localparam int ERR_W     = 3;
  localparam int LOCKCFG_W = 9;
  localparam int ZONECFG_W = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 9;
  localparam int MAX_LOGICAL_ZONES  = 4;
  localparam int MAX_PHYSICAL_ZONES = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOGICAL_ZONES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHYS_ZONES    = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_QUERY          = 4'd0,
    CMD_INIT_JOURNAL   = 4'd1,
    CMD_ACQUIRE        = 4'd2,
    CMD_RELEASE        = 4'd3,
    CMD_JOURNAL_REL    = 4'd4,
    CMD_REMOTE_REL     = 4'd5,
    CMD_ACK            = 4'd6,
    CMD_SUSPEND        = 4'd7,
    CMD_RESUME         = 4'd8
  } cmd_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE      = 3'd0,
    ERR_OVERFLOW  = 3'd1,
    ERR_UNDERFLOW = 3'd2,
    ERR_RANGE     = 3'd3,
    ERR_IN_USE    = 3'd4
  } err_e;

  typedef struct packed {
    logic               en;
    logic [LOCK_W-1:0]  lock;
    logic [ZONE_W-1:0]  zone;
  } rd_req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  jc;
    logic [CNT_W-1:0]  jd;
    logic [HOLD_W-1:0] lh;
    logic [HOLD_W-1:0] ph;
    logic [CNT_W-1:0]  lc;
    logic [CNT_W-1:0]  pc;
  } rd_data_t;

  typedef struct packed {
    logic               jc_we;
    logic               jd_we;
    logic               lh_we;
    logic               ph_we;
    logic               lc_we;
    logic               pc_we;
    logic [LOCK_W-1:0]  lock;
    logic [ZONE_W-1:0]  zone;
    logic [CNT_W-1:0]   jc;
    logic [CNT_W-1:0]   jd;
    logic [HOLD_W-1:0]  hold;
    logic [CNT_W-1:0]   cnt;
  } wr_req_t;

endpackage
`default_nettype wire

// ----- rtl/core/zlrc_store.sv -----
// Counter and holder memories with a clearing sweep after reset.
`timescale 1ns / 1ps
`default_nettype none
module zlrc_store (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire zlrc_pkg::rd_req_t rd_i,
  output zlrc_pkg::rd_data_t     rd_o,
  input  wire zlrc_pkg::wr_req_t wr_i,
  output logic                   busy_o
);

  logic [zlrc_pkg::CNT_W-1:0]  jc_mem [zlrc_pkg::NUM_LOCKS];
  logic [zlrc_pkg::CNT_W-1:0]  jd_mem [zlrc_pkg::NUM_LOCKS];
  logic [zlrc_pkg::HOLD_W-1:0] lh_mem [zlrc_pkg::NUM_LOCKS];
  logic [zlrc_pkg::HOLD_W-1:0] ph_mem [zlrc_pkg::NUM_LOCKS];
  logic [zlrc_pkg::CNT_W-1:0]  lc_mem [zlrc_pkg::NUM_LOCKS * 4];
  logic [zlrc_pkg::CNT_W-1:0]  pc_mem [zlrc_pkg::NUM_LOCKS * 4];

  logic [zlrc_pkg::ZADDR_W-1:0] clr_q, clr_d;
  logic                         busy_q, busy_d;
  zlrc_pkg::rd_data_t           rd_q;

  logic [zlrc_pkg::ZADDR_W-1:0] rd_za, wr_za;
  logic [zlrc_pkg::LOCK_W-1:0]  clr_lock;

  assign rd_za    = {rd_i.zone, rd_i.lock};
  assign wr_za    = {wr_i.zone, wr_i.lock};
  assign clr_lock = clr_q[zlrc_pkg::LOCK_W-1:0];

  // The sweep visits every zone-count entry once; the per-lock tables are
  // cleared repeatedly on the way, which is harmless.
  always_comb begin
    clr_d  = clr_q;
    busy_d = busy_q;
    if (busy_q) begin
      clr_d = clr_q + 1'b1;
      if (clr_q == {zlrc_pkg::ZADDR_W{1'b1}}) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      busy_q <= 1'b1;
    end else begin
      clr_q  <= clr_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      jc_mem[clr_lock] <= '0;
      jd_mem[clr_lock] <= '0;
      lh_mem[clr_lock] <= '0;
      ph_mem[clr_lock] <= '0;
      lc_mem[clr_q]    <= '0;
      pc_mem[clr_q]    <= '0;
    end else begin
      if (wr_i.jc_we) begin
        jc_mem[wr_i.lock] <= wr_i.jc;
      end
      if (wr_i.jd_we) begin
        jd_mem[wr_i.lock] <= wr_i.jd;
      end
      if (wr_i.lh_we) begin
        lh_mem[wr_i.lock] <= wr_i.hold;
      end
      if (wr_i.ph_we) begin
        ph_mem[wr_i.lock] <= wr_i.hold;
      end
      if (wr_i.lc_we) begin
        lc_mem[wr_za] <= wr_i.cnt;
      end
      if (wr_i.pc_we) begin
        pc_mem[wr_za] <= wr_i.cnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_q.jc <= jc_mem[rd_i.lock];
      rd_q.jd <= jd_mem[rd_i.lock];
      rd_q.lh <= lh_mem[rd_i.lock];
      rd_q.ph <= ph_mem[rd_i.lock];
      rd_q.lc <= lc_mem[rd_za];
      rd_q.pc <= pc_mem[rd_za];
    end
  end

  assign rd_o   = rd_q;
  assign busy_o = busy_q;

endmodule
`default_nettype wire

// ----- rtl/core/zoned_lock_reference_counter_top.sv -----
// Top level of the zoned lock reference counter: control, update logic, ports.
//
// Commands arrive on the slave stream; every accepted item yields exactly one
// result item on the master stream. s_axis_tdata carries, from bit 0 up:
// cmd[3:0], lock_index[11:4], zone_index[13:12], init_value[29:14]; the zone
// kind travels on s_axis_tuser. m_axis_tdata carries, from bit 0 up: notify,
// locked, success, count_after[18:3], error[21:19].
// In the accept cycle the per-lock and per-zone memories are read; in the
// update state, once the output register is free or being taken, the read
// data is modified, written back and the result is loaded into the output
// register. Each memory has one read port and one write port, and the next
// item is read only after the write of the previous one, so same-entry
// accesses never overlap.
// After reset the memories are cleared by a sweep over every zone-count
// entry, during which s_axis_tready stays low; configuration writes are taken
// at any time on the cfg port. When the receiver stalls, one result waits in
// the output register and the block holds the next item in its update cycle,
// so no result is lost or reordered.
`timescale 1ns / 1ps
`default_nettype none
module zoned_lock_reference_counter_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // cmd, lock_index, zone_index, init_value
  input  wire logic        s_axis_tuser,  // zone_kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // notify, locked, success, count_after, error
  input  wire logic        cfg_we_i,
  input  wire logic [zlrc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [zlrc_pkg::CFG_DAT_W-1:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  typedef enum logic [2:0] {
    NS_IDLE      = 3'b001,
    NS_NOTIFYING = 3'b010,
    NS_SUSPENDED = 3'b100
  } nstate_e;

  localparam int CNT_W  = zlrc_pkg::CNT_W;
  localparam int HOLD_W = zlrc_pkg::HOLD_W;

  state_e  state_q, state_d;
  nstate_e nst_q, nst_d;

  logic [zlrc_pkg::LOCKCFG_W-1:0] lock_cnt_q;
  logic [zlrc_pkg::ZONECFG_W-1:0] lzone_cnt_q, pzone_cnt_q;

  // Registered command fields.
  logic [zlrc_pkg::CMD_W-1:0]  cmd_q;
  logic [zlrc_pkg::LOCK_W-1:0] lock_q;
  logic [zlrc_pkg::ZONE_W-1:0] zone_q;
  logic                        kind_q;
  logic [CNT_W-1:0]            initv_q;
  logic                        lock_ok_q, zone_ok_q;

  logic                         m_valid_q, m_valid_d;
  logic [23:0]                  m_data_q;

  zlrc_pkg::rd_req_t  rd_req;
  zlrc_pkg::rd_data_t rd;
  zlrc_pkg::wr_req_t  wr;
  logic               clr_busy;

  logic s_acc, exec_done;
  logic [zlrc_pkg::CMD_W-1:0]  in_cmd;
  logic [zlrc_pkg::LOCK_W-1:0] in_lock;
  logic [zlrc_pkg::ZONE_W-1:0] in_zone;
  logic                        in_lock_ok, in_zone_ok;
  logic [zlrc_pkg::ZONECFG_W-1:0] zlim;

  // Update results.
  logic              r_notify, r_locked, r_success;
  logic [CNT_W-1:0]  r_cnt;
  logic [zlrc_pkg::ERR_W-1:0] r_err;
  logic              want_notify;
  logic [CNT_W-1:0]  jc_new, jd_new, c_old, c_new;
  logic [HOLD_W-1:0] h_old, h_new;
  logic              jc_we, jd_we, h_we, c_we;

  assign in_cmd  = s_axis_tdata[3:0];
  assign in_lock = s_axis_tdata[11:4];
  assign in_zone = s_axis_tdata[13:12];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign exec_done     = (state_q == ST_EXEC) && (!m_valid_q || m_axis_tready);

  // Lock and zone limits saturate at the table sizes.
  assign in_lock_ok = lock_cnt_q[zlrc_pkg::LOCKCFG_W-1] ||
                      ({1'b0, in_lock} < lock_cnt_q);
  assign zlim       = s_axis_tuser ? pzone_cnt_q : lzone_cnt_q;
  assign in_zone_ok = zlim[zlrc_pkg::ZONECFG_W-1] ||
                      ({1'b0, in_zone} < zlim);

  assign rd_req.en   = s_acc;
  assign rd_req.lock = in_lock;
  assign rd_req.zone = in_zone;

  zlrc_store u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (rd_req),
    .rd_o   (rd),
    .wr_i   (wr),
    .busy_o (clr_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_cnt_q  <= zlrc_pkg::LOCKCFG_W'(zlrc_pkg::NUM_LOCKS);
      lzone_cnt_q <= zlrc_pkg::ZONECFG_W'(zlrc_pkg::MAX_LOGICAL_ZONES);
      pzone_cnt_q <= zlrc_pkg::ZONECFG_W'(zlrc_pkg::MAX_PHYSICAL_ZONES);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        zlrc_pkg::CFG_LOCK_COUNT:    lock_cnt_q  <= cfg_wdata_i;
        zlrc_pkg::CFG_LOGICAL_ZONES: lzone_cnt_q <= cfg_wdata_i[zlrc_pkg::ZONECFG_W-1:0];
        zlrc_pkg::CFG_PHYS_ZONES:    pzone_cnt_q <= cfg_wdata_i[zlrc_pkg::ZONECFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      cmd_q     <= in_cmd;
      lock_q    <= in_lock;
      zone_q    <= in_zone;
      kind_q    <= s_axis_tuser;
      initv_q   <= s_axis_tdata[29:14];
      lock_ok_q <= in_lock_ok;
      zone_ok_q <= in_zone_ok;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (!clr_busy) state_d = ST_IDLE;
      ST_IDLE:  if (s_acc) state_d = ST_EXEC;
      ST_EXEC:  if (exec_done) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  assign h_old = kind_q ? rd.ph : rd.lh;
  assign c_old = kind_q ? rd.pc : rd.lc;

  always_comb begin
    r_notify    = 1'b0;
    r_success   = 1'b0;
    r_cnt       = '0;
    r_err       = zlrc_pkg::ERR_NONE;
    want_notify = 1'b0;
    jc_new      = rd.jc;
    jd_new      = rd.jd;
    h_new       = h_old;
    c_new       = c_old;
    jc_we       = 1'b0;
    jd_we       = 1'b0;
    h_we        = 1'b0;
    c_we        = 1'b0;
    nst_d       = nst_q;

    if (cmd_q <= zlrc_pkg::CMD_REMOTE_REL && !lock_ok_q) begin
      r_err = zlrc_pkg::ERR_RANGE;
    end else begin
      case (cmd_q)
        zlrc_pkg::CMD_QUERY: begin
          r_cnt = CNT_W'(h_old);
        end
        zlrc_pkg::CMD_INIT_JOURNAL: begin
          if (rd.jc != rd.jd) r_err = zlrc_pkg::ERR_IN_USE;
          jc_new = initv_q;
          jd_new = '0;
          jc_we  = 1'b1;
          jd_we  = 1'b1;
          r_cnt  = initv_q;
        end
        zlrc_pkg::CMD_ACQUIRE: begin
          if (!zone_ok_q) begin
            r_err = zlrc_pkg::ERR_RANGE;
          end else begin
            if (c_old == {CNT_W{1'b1}}) begin
              r_err = zlrc_pkg::ERR_OVERFLOW;
            end else begin
              if (c_old == '0) begin
                h_new = h_old + 1'b1;
                h_we  = 1'b1;
              end
              c_new = c_old + 1'b1;
              c_we  = 1'b1;
            end
            r_cnt = c_new;
          end
        end
        zlrc_pkg::CMD_RELEASE: begin
          if (!zone_ok_q) begin
            r_err = zlrc_pkg::ERR_RANGE;
          end else begin
            if (c_old == '0) begin
              r_err = zlrc_pkg::ERR_UNDERFLOW;
            end else begin
              c_new = c_old - 1'b1;
              c_we  = 1'b1;
              // The last zone to let go frees the lock for this zone kind.
              if (c_new == '0 && h_old != '0) begin
                h_new       = h_old - 1'b1;
                h_we        = 1'b1;
                want_notify = (h_new == '0);
              end
            end
            r_cnt = c_new;
          end
        end
        zlrc_pkg::CMD_JOURNAL_REL: begin
          if (rd.jc == rd.jd || rd.jc == '0) begin
            r_err = zlrc_pkg::ERR_UNDERFLOW;
          end else begin
            jc_new      = rd.jc - 1'b1;
            jc_we       = 1'b1;
            want_notify = (jc_new == rd.jd);
          end
          r_cnt = jc_new;
        end
        zlrc_pkg::CMD_REMOTE_REL: begin
          if (rd.jd >= rd.jc) begin
            r_err = zlrc_pkg::ERR_UNDERFLOW;
          end else begin
            jd_new = rd.jd + 1'b1;
            jd_we  = 1'b1;
          end
          r_cnt = jd_new;
        end
        zlrc_pkg::CMD_ACK: begin
          nst_d = NS_IDLE;
        end
        zlrc_pkg::CMD_SUSPEND: begin
          if (nst_q == NS_IDLE) begin
            nst_d     = NS_SUSPENDED;
            r_success = 1'b1;
          end else if (nst_q == NS_SUSPENDED) begin
            r_success = 1'b1;
          end
        end
        zlrc_pkg::CMD_RESUME: begin
          if (nst_q == NS_SUSPENDED) begin
            nst_d     = NS_IDLE;
            r_success = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (want_notify && nst_q == NS_IDLE) begin
      nst_d    = NS_NOTIFYING;
      r_notify = 1'b1;
    end

    r_locked = (cmd_q <= zlrc_pkg::CMD_REMOTE_REL) && lock_ok_q &&
               ((jc_new != jd_new) || (h_new != '0));
  end

  always_comb begin
    wr.lock  = lock_q;
    wr.zone  = zone_q;
    wr.jc    = jc_new;
    wr.jd    = jd_new;
    wr.hold  = h_new;
    wr.cnt   = c_new;
    wr.jc_we = exec_done && jc_we;
    wr.jd_we = exec_done && jd_we;
    wr.lh_we = exec_done && h_we && !kind_q;
    wr.ph_we = exec_done && h_we && kind_q;
    wr.lc_we = exec_done && c_we && !kind_q;
    wr.pc_we = exec_done && c_we && kind_q;
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (exec_done) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      nst_q     <= NS_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (exec_done) begin
        nst_q <= nst_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_done) begin
      m_data_q <= {2'b00, r_err, r_cnt, r_success, r_locked, r_notify};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // No item is taken while the memories are still being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !clr_busy)
    else $error("item accepted during memory clear");

  // Memory writes only happen when an update completes.
  a_write_only_on_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr.jc_we || wr.jd_we || wr.lh_we || wr.ph_we || wr.lc_we || wr.pc_we)
    |-> exec_done)
    else $error("memory written outside an update");

  // An issued notification always leaves the block in the notifying state.
  a_notify_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_done && r_notify) |=> (nst_q == NS_NOTIFYING))
    else $error("notification without notifying state");

  // A notification is issued only from the idle notification state.
  a_notify_from_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_done && r_notify) |-> (nst_q == NS_IDLE))
    else $error("notification while one is in flight or suspended");

  // Every accepted item puts the block in the update state in the following cycle.
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> (state_q == ST_EXEC))
    else $error("accepted item not processed");

endmodule
`default_nettype wire

// ----- verif/tb_zoned_lock_reference_counter_top.sv -----
// Self-checking stream testbench for the zoned lock reference counter top level.
`timescale 1ns / 1ps
module tb_zoned_lock_reference_counter_top;
  import zlrc_pkg::*;

  localparam int IDLE_PCT       = 18;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 6;

  typedef enum logic [1:0] {
    OWNER_IDLE,
    OWNER_NOTIFYING,
    OWNER_SUSPENDED
  } owner_state_e;

  typedef struct packed {
    logic             notify;
    logic             locked;
    logic             success;
    logic [CNT_W-1:0] count;
    err_e             err;
  } outcome_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata  = '0;  // cmd, lock_index, zone_index, init_value
  logic                 s_axis_tuser  = 1'b0;  // zone_kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [23:0]          m_axis_tdata;  // notify, locked, success, count_after, error
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = CFG_LOCK_COUNT;
  logic [CFG_DAT_W-1:0] cfg_wdata_i   = '0;

  // Predicted state of the counter tables.
  logic [CNT_W-1:0]  journal_total  [NUM_LOCKS] = '{default: '0};
  logic [CNT_W-1:0]  journal_remote [NUM_LOCKS] = '{default: '0};
  logic [CNT_W-1:0]  logical_ref    [MAX_LOGICAL_ZONES][NUM_LOCKS] = '{default: '{default: '0}};
  logic [CNT_W-1:0]  physical_ref   [MAX_PHYSICAL_ZONES][NUM_LOCKS] = '{default: '{default: '0}};
  logic [HOLD_W-1:0] logical_holds  [NUM_LOCKS] = '{default: '0};
  logic [HOLD_W-1:0] physical_holds [NUM_LOCKS] = '{default: '0};
  owner_state_e      owner_state    = OWNER_IDLE;

  // Effective register settings, already clamped to the table sizes.
  int lock_limit   = NUM_LOCKS;
  int lzone_limit  = MAX_LOGICAL_ZONES;
  int pzone_limit  = MAX_PHYSICAL_ZONES;

  outcome_t pending_outcomes[$];
  int       mismatch_count = 0;
  int       checked_count  = 0;
  bit       calm           = 1'b0;
  int       hold_asked     = 0;
  int       hold_served    = 0;
  int       hold_left      = 0;
  int       quiet_cycles   = 0;

  zoned_lock_reference_counter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic lock_is_held(logic [LOCK_W-1:0] lk, logic phys);
    logic [HOLD_W-1:0] h;
    h = phys ? physical_holds[lk] : logical_holds[lk];
    return (journal_total[lk] != journal_remote[lk]) || (h != '0);
  endfunction

  function automatic logic raise_notify();
    if (owner_state == OWNER_IDLE) begin
      owner_state = OWNER_NOTIFYING;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Applies one command to the predicted state and returns the result it causes.
  function automatic outcome_t compute_outcome(logic [CMD_W-1:0] cmd, logic [LOCK_W-1:0] lk,
                                               logic phys, logic [ZONE_W-1:0] zn,
                                               logic [CNT_W-1:0] initv);
    outcome_t          r;
    logic              lock_ok;
    logic [CNT_W-1:0]  c;
    logic [HOLD_W-1:0] h;
    int                zone_lim;
    r = '0;
    r.err = ERR_NONE;
    lock_ok = int'(lk) < lock_limit;
    if (cmd <= CMD_REMOTE_REL && !lock_ok) begin
      r.err = ERR_RANGE;
    end else begin
      case (cmd)
        CMD_QUERY: begin
          r.count = CNT_W'(phys ? physical_holds[lk] : logical_holds[lk]);
        end
        CMD_INIT_JOURNAL: begin
          if (journal_total[lk] != journal_remote[lk]) r.err = ERR_IN_USE;
          journal_total[lk]  = initv;
          journal_remote[lk] = '0;
          r.count = initv;
        end
        CMD_ACQUIRE, CMD_RELEASE: begin
          zone_lim = phys ? pzone_limit : lzone_limit;
          if (int'(zn) >= zone_lim) begin
            r.err = ERR_RANGE;
          end else begin
            c = phys ? physical_ref[zn][lk] : logical_ref[zn][lk];
            h = phys ? physical_holds[lk] : logical_holds[lk];
            if (cmd == CMD_ACQUIRE) begin
              if (c == '1) begin
                r.err = ERR_OVERFLOW;
              end else begin
                if (c == '0) h = h + 1'b1;
                c = c + 1'b1;
              end
            end else if (c == '0) begin
              r.err = ERR_UNDERFLOW;
            end else begin
              c = c - 1'b1;
              if (c == '0 && h != '0) begin
                h = h - 1'b1;
                if (h == '0) r.notify = raise_notify();
              end
            end
            if (phys) begin
              physical_ref[zn][lk] = c;
              physical_holds[lk]   = h;
            end else begin
              logical_ref[zn][lk] = c;
              logical_holds[lk]   = h;
            end
            r.count = c;
          end
        end
        CMD_JOURNAL_REL: begin
          if (journal_total[lk] == journal_remote[lk] || journal_total[lk] == '0) begin
            r.err = ERR_UNDERFLOW;
          end else begin
            journal_total[lk] = journal_total[lk] - 1'b1;
            if (journal_total[lk] == journal_remote[lk]) r.notify = raise_notify();
          end
          r.count = journal_total[lk];
        end
        CMD_REMOTE_REL: begin
          if (journal_remote[lk] >= journal_total[lk]) r.err = ERR_UNDERFLOW;
          else journal_remote[lk] = journal_remote[lk] + 1'b1;
          r.count = journal_remote[lk];
        end
        CMD_ACK: begin
          owner_state = OWNER_IDLE;
        end
        CMD_SUSPEND: begin
          if (owner_state == OWNER_IDLE) begin
            owner_state = OWNER_SUSPENDED;
            r.success = 1'b1;
          end else if (owner_state == OWNER_SUSPENDED) begin
            r.success = 1'b1;
          end
        end
        CMD_RESUME: begin
          if (owner_state == OWNER_SUSPENDED) begin
            owner_state = OWNER_IDLE;
            r.success = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (cmd <= CMD_REMOTE_REL && lock_ok) r.locked = lock_is_held(lk, phys);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("[%0t] result %0d: %s is %0d, expected %0d", $realtime, checked_count, field,
             got, want);
    mismatch_count++;
  endtask

  // Every task below starts and ends at a rising clock edge.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [LOCK_W-1:0] lk,
                              input logic phys, input logic [ZONE_W-1:0] zn,
                              input logic [CNT_W-1:0] initv);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < IDLE_PCT) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, initv, zn, lk, cmd};
    s_axis_tuser  <= phys;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_outcomes.push_back(compute_outcome(cmd, lk, phys, zn, initv));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apply_config(input logic [LOCKCFG_W-1:0] locks,
                              input logic [ZONECFG_W-1:0] lzones,
                              input logic [ZONECFG_W-1:0] pzones);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_LOCK_COUNT;
    cfg_wdata_i <= locks;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_LOGICAL_ZONES;
    cfg_wdata_i <= CFG_DAT_W'(lzones);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_PHYS_ZONES;
    cfg_wdata_i <= CFG_DAT_W'(pzones);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    lock_limit  = (int'(locks) > NUM_LOCKS) ? NUM_LOCKS : int'(locks);
    lzone_limit = (int'(lzones) > MAX_LOGICAL_ZONES) ? MAX_LOGICAL_ZONES : int'(lzones);
    pzone_limit = (int'(pzones) > MAX_PHYSICAL_ZONES) ? MAX_PHYSICAL_ZONES : int'(pzones);
  endtask

  // Acquire and release make up half the traffic, mostly on a few hot locks and on the range
  // boundary, so that counts rise and fall and notifications cycle through their states.
  task automatic send_random_command();
    logic [CMD_W-1:0]  cmd;
    logic [LOCK_W-1:0] lk;
    logic [CNT_W-1:0]  initv;
    int                roll;
    int                edge_lock;
    roll = $urandom_range(0, 99);
    if (roll < 26)      cmd = CMD_ACQUIRE;
    else if (roll < 50) cmd = CMD_RELEASE;
    else if (roll < 58) cmd = CMD_QUERY;
    else if (roll < 64) cmd = CMD_INIT_JOURNAL;
    else if (roll < 74) cmd = CMD_JOURNAL_REL;
    else if (roll < 80) cmd = CMD_REMOTE_REL;
    else if (roll < 87) cmd = CMD_ACK;
    else if (roll < 91) cmd = CMD_SUSPEND;
    else if (roll < 95) cmd = CMD_RESUME;
    else                cmd = CMD_W'($urandom_range(9, 15));
    roll = $urandom_range(0, 99);
    edge_lock = lock_limit - 1 + $urandom_range(0, 1);
    if (roll < 60)      lk = LOCK_W'($urandom_range(0, 3));
    else if (roll < 75) lk = LOCK_W'((edge_lock > 255) ? 255 : edge_lock);
    else                lk = LOCK_W'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (roll < 70)      initv = CNT_W'($urandom_range(0, 4));
    else if (roll < 85) initv = '1;
    else                initv = CNT_W'($urandom);
    send_command(cmd, lk, 1'($urandom_range(0, 1)), ZONE_W'($urandom_range(0, 3)), initv);
  endtask

  task automatic test_directed_cases();
    send_command(CMD_QUERY, 8'd0, 1'b0, 2'd0, 16'd0);
    send_command(CMD_ACQUIRE, 8'd0, 1'b0, 2'd0, 16'd0);
    send_command(CMD_ACQUIRE, 8'd0, 1'b0, 2'd3, 16'd0);
    send_command(CMD_ACQUIRE, 8'd255, 1'b1, 2'd3, 16'd0);
    send_command(CMD_QUERY, 8'd0, 1'b0, 2'd0, 16'd0);
    send_command(CMD_RELEASE, 8'd0, 1'b0, 2'd0, 16'd0);
    // Releasing a count that is already zero underflows.
    send_command(CMD_RELEASE, 8'd0, 1'b0, 2'd0, 16'd0);
    send_command(CMD_RELEASE, 8'd0, 1'b0, 2'd3, 16'd0);
    // A notification is already in flight, so this one is swallowed.
    send_command(CMD_RELEASE, 8'd255, 1'b1, 2'd3, 16'd0);
    send_command(CMD_ACK, 8'd0, 1'b0, 2'd0, 16'd0);
    send_command(CMD_SUSPEND, 8'd0, 1'b0, 2'd0, 16'd0);
    send_command(CMD_SUSPEND, 8'd0, 1'b0, 2'd0, 16'd0);
    send_command(CMD_INIT_JOURNAL, 8'd7, 1'b0, 2'd0, 16'hFFFF);
    send_command(CMD_JOURNAL_REL, 8'd7, 1'b0, 2'd0, 16'd0);
    send_command(CMD_REMOTE_REL, 8'd7, 1'b1, 2'd0, 16'd0);
    send_command(CMD_INIT_JOURNAL, 8'd7, 1'b1, 2'd0, 16'd2);
    send_command(CMD_JOURNAL_REL, 8'd7, 1'b0, 2'd0, 16'd0);
    send_command(CMD_JOURNAL_REL, 8'd7, 1'b0, 2'd0, 16'd0);
    send_command(CMD_JOURNAL_REL, 8'd7, 1'b0, 2'd0, 16'd0);
    send_command(CMD_REMOTE_REL, 8'd7, 1'b0, 2'd0, 16'd0);
    send_command(CMD_RESUME, 8'hFF, 1'b1, 2'd3, 16'hFFFF);
    send_command(CMD_RESUME, 8'd0, 1'b0, 2'd0, 16'd0);
    send_command(CMD_W'(15), 8'hFF, 1'b1, 2'd3, 16'hFFFF);
    send_command(CMD_ACQUIRE, 8'd9, 1'b1, 2'd1, 16'd0);
    send_command(CMD_RELEASE, 8'd9, 1'b1, 2'd1, 16'd0);
    // Suspending while a notification is outstanding fails.
    send_command(CMD_SUSPEND, 8'd0, 1'b0, 2'd0, 16'd0);
    send_command(CMD_ACK, 8'd0, 1'b0, 2'd0, 16'd0);
  endtask

  // A zone count climbs well above one and comes back down; the last release
  // finds it at zero and underflows.
  task automatic test_count_rise_and_fall();
    calm = 1'b1;
    repeat (24) send_command(CMD_ACQUIRE, 8'd1, 1'b0, 2'd1, 16'd0);
    send_command(CMD_QUERY, 8'd1, 1'b0, 2'd0, 16'd0);
    repeat (25) send_command(CMD_RELEASE, 8'd1, 1'b0, 2'd1, 16'd0);
    send_command(CMD_QUERY, 8'd1, 1'b0, 2'd0, 16'd0);
    calm = 1'b0;
  endtask

  task automatic test_random_settings();
    apply_config(9'd1, 3'd1, 3'd1);
    repeat (150) send_random_command();
    apply_config(9'd256, 3'd4, 3'd4);
    calm = 1'b1;
    repeat (200) send_random_command();
    calm = 1'b0;
    apply_config(9'd511, 3'd7, 3'd7);
    repeat (150) send_random_command();
    apply_config(9'd100, 3'd2, 3'd3);
    repeat (220) send_random_command();
  endtask

  task automatic test_receiver_hold();
    hold_asked++;
    repeat (40) send_random_command();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_count_rise_and_fall();
    test_random_settings();
    test_receiver_hold();
    wait_drained();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served   <= hold_served + 1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result, tdata", m_axis_tdata, 0);
      end else begin
        want = pending_outcomes.pop_front();
        if (m_axis_tdata[0] !== want.notify)
          report_mismatch("notify", m_axis_tdata[0], want.notify);
        if (m_axis_tdata[1] !== want.locked)
          report_mismatch("locked", m_axis_tdata[1], want.locked);
        if (m_axis_tdata[2] !== want.success)
          report_mismatch("success", m_axis_tdata[2], want.success);
        if (m_axis_tdata[18:3] !== want.count)
          report_mismatch("count_after", m_axis_tdata[18:3], want.count);
        if (m_axis_tdata[21:19] !== want.err)
          report_mismatch("error", m_axis_tdata[21:19], want.err);
      end
      checked_count++;
    end
  end

  // The clearing sweep after reset keeps the input stalled.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no item moved for %0d cycles", $realtime, quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
